### rtl/core/ts2cal_pkg.sv
// Constants, stage record and month table for the timestamp to calendar converter.
package ts2cal_pkg;

  localparam int NUM_STAGES = 11;

  // Seconds from 0001-01-01 to the Unix epoch, and the last second of year 9999.
  localparam logic [40:0] YEAR1_TO_UNIX = 41'd62135596800;
  localparam logic [40:0] SECS_MAX      = 41'd315537897599;

  localparam logic [9:0]  DIV_DAY128     = 10'd675;   // 86400 / 128
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN   = 12'd60;
  localparam logic [21:0] DAYS_PER_WEEK  = 22'd7;
  localparam logic [21:0] DAYS_400Y      = 22'd146097;
  localparam logic [17:0] DAYS_100Y      = 18'd36524;
  localparam logic [15:0] DAYS_4Y        = 16'd1461;
  localparam logic [10:0] DAYS_1Y        = 11'd365;
  localparam logic [8:0]  LEAP_DAY_YDAY  = 9'd59;

  // Reciprocals for division by constants. RECIP_DAY128 is a floor value and
  // gets a one-step correction; the others are ceil values, exact over their range.
  localparam logic [31:0] RECIP_DAY128 = 32'((64'd1 << 41) / 64'd675);
  localparam logic [22:0] RECIP_400Y   = 23'((64'd1 << 40) / 64'd146097 + 64'd1);
  localparam logic [17:0] RECIP_HOUR   = 18'((64'd1 << 29) / 64'd3600 + 64'd1);
  localparam logic [22:0] RECIP_WEEK   = 23'((64'd1 << 25) / 64'd7 + 64'd1);
  localparam logic [12:0] RECIP_MIN    = 13'((64'd1 << 18) / 64'd60 + 64'd1);
  localparam logic [16:0] RECIP_4Y     = 17'((64'd1 << 27) / 64'd1461 + 64'd1);

  typedef struct packed {
    logic        oor;
    logic [38:0] s;       // seconds since 0001-01-01
    logic [22:0] qe;      // day estimate
    logic [21:0] days;
    logic [16:0] tod;
    logic [4:0]  n400;
    logic [4:0]  hr;
    logic [18:0] q7;
    logic [17:0] d1;
    logic [11:0] remh;
    logic [2:0]  wd;
    logic [1:0]  n100;
    logic [15:0] d2;
    logic [5:0]  mi;
    logic [4:0]  n4;
    logic [5:0]  se;
    logic [10:0] d3;
    logic [8:0]  yday;
    logic [13:0] year;
    logic        leap;
    logic [8:0]  dd;
    logic        feb29;
    logic [3:0]  mon;
    logic [4:0]  dom;
    logic [8:0]  doy;
  } stage_t;

  // Day of year (from 0) on which month idx+1 starts, common year.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/timestamp_to_calendar_fields_top.sv
// Top level: Unix seconds plus UTC offset to Gregorian calendar fields.
// Eleven-stage pipeline (stages 0 to 10); the result is read from the stage 10 register.
// Throughput is one item per cycle while out_tready is high; the longest paths are the reciprocal multipliers.
// Each stage holds its item under back-pressure and fills bubbles ahead of it.
// Synchronous active-low reset empties the pipeline and sets the offset to 0.
module timestamp_to_calendar_fields_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [17:0] cfg_wr_data,   // utc_offset_seconds
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // [38:0] unix_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] year, [17:14] month, [22:18] day_of_month, [31:23] day_of_year,
  // [34:32] weekday, [39:35] hour, [45:40] minute, [51:46] second
  output logic [55:0] out_tdata,
  output logic [0:0]  out_tuser      // [0] out_of_range
);

  localparam int NS = ts2cal_pkg::NUM_STAGES;

  logic [17:0]         offset_r;
  ts2cal_pkg::stage_t  st_r   [NS];
  ts2cal_pkg::stage_t  st_nxt [NS];
  logic [NS-1:0]       vld_r;
  logic [NS:0]         rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    logic [40:0] loc41;
    logic [40:0] s41;
    logic [63:0] p2;
    logic [32:0] r33;
    logic [10:0] rr;
    logic [44:0] p4;
    logic [34:0] p4h;
    logic [44:0] p4w;
    logic [21:0] dp1;
    logic [21:0] d1w;
    logic [16:0] rhw;
    logic [21:0] ww;
    logic [17:0] d2w;
    logic [24:0] p6;
    logic [32:0] p7;
    logic [11:0] sw;
    logic [15:0] d3w;
    logic [1:0]  n1;
    logic [10:0] yw;
    logic [3:0]  mon0;
    logic [8:0]  mbeg;
    logic [8:0]  domw;

    // Stage 0: add offset, move origin to 0001-01-01, range check.
    st_nxt[0] = '0;
    loc41 = {{2{in_tdata[38]}}, in_tdata[38:0]} + {{23{offset_r[17]}}, offset_r};
    s41   = loc41 + ts2cal_pkg::YEAR1_TO_UNIX;
    st_nxt[0].oor = s41[40] || (s41 > ts2cal_pkg::SECS_MAX);
    st_nxt[0].s   = s41[38:0];

    // Stage 1: day estimate from (s >> 7) / 675.
    st_nxt[1] = st_r[0];
    p2 = {32'd0, st_r[0].s[38:7]} * {32'd0, ts2cal_pkg::RECIP_DAY128};
    st_nxt[1].qe = p2[63:41];

    // Stage 2: correct estimate (may be one low), time of day.
    st_nxt[2] = st_r[1];
    r33 = {1'b0, st_r[1].s[38:7]} - 33'(33'(st_r[1].qe) * 33'(ts2cal_pkg::DIV_DAY128));
    rr  = r33[10:0];
    if (rr >= 11'(ts2cal_pkg::DIV_DAY128)) begin
      st_nxt[2].days = 22'(st_r[1].qe) + 22'd1;
      rr = rr - 11'(ts2cal_pkg::DIV_DAY128);
    end else begin
      st_nxt[2].days = 22'(st_r[1].qe);
    end
    st_nxt[2].tod = {rr[9:0], st_r[1].s[6:0]};

    // Stage 3: 400-year count, hour, week count.
    st_nxt[3] = st_r[2];
    p4  = 45'(st_r[2].days) * 45'(ts2cal_pkg::RECIP_400Y);
    st_nxt[3].n400 = p4[44:40];
    p4h = 35'(st_r[2].tod) * 35'(ts2cal_pkg::RECIP_HOUR);
    st_nxt[3].hr = p4h[33:29];
    dp1 = st_r[2].days + 22'd1;
    p4w = 45'(dp1) * 45'(ts2cal_pkg::RECIP_WEEK);
    st_nxt[3].q7 = p4w[43:25];

    // Stage 4: remainders of the above.
    st_nxt[4] = st_r[3];
    d1w = st_r[3].days - 22'(22'(st_r[3].n400) * ts2cal_pkg::DAYS_400Y);
    st_nxt[4].d1 = d1w[17:0];
    rhw = st_r[3].tod - 17'(17'(st_r[3].hr) * ts2cal_pkg::SECS_PER_HOUR);
    st_nxt[4].remh = rhw[11:0];
    ww = (st_r[3].days + 22'd1) - 22'(22'(st_r[3].q7) * ts2cal_pkg::DAYS_PER_WEEK);
    st_nxt[4].wd = ww[2:0];

    // Stage 5: century within the 400-year cycle (last day stays in century 3), minute.
    st_nxt[5] = st_r[4];
    if (st_r[4].d1 >= 18'(3 * ts2cal_pkg::DAYS_100Y)) begin
      st_nxt[5].n100 = 2'd3;
    end else if (st_r[4].d1 >= 18'(2 * ts2cal_pkg::DAYS_100Y)) begin
      st_nxt[5].n100 = 2'd2;
    end else if (st_r[4].d1 >= ts2cal_pkg::DAYS_100Y) begin
      st_nxt[5].n100 = 2'd1;
    end else begin
      st_nxt[5].n100 = 2'd0;
    end
    d2w = st_r[4].d1 - 18'(18'(st_nxt[5].n100) * ts2cal_pkg::DAYS_100Y);
    st_nxt[5].d2 = d2w[15:0];
    p6 = 25'(st_r[4].remh) * 25'(ts2cal_pkg::RECIP_MIN);
    st_nxt[5].mi = p6[23:18];

    // Stage 6: 4-year count, second.
    st_nxt[6] = st_r[5];
    p7 = 33'(st_r[5].d2) * 33'(ts2cal_pkg::RECIP_4Y);
    st_nxt[6].n4 = p7[31:27];
    sw = st_r[5].remh - 12'(12'(st_r[5].mi) * ts2cal_pkg::SECS_PER_MIN);
    st_nxt[6].se = sw[5:0];

    // Stage 7: day within the 4-year cycle.
    st_nxt[7] = st_r[6];
    d3w = st_r[6].d2 - 16'(16'(st_r[6].n4) * ts2cal_pkg::DAYS_4Y);
    st_nxt[7].d3 = d3w[10:0];

    // Stage 8: year within the cycle (leap day of a cycle stays in year 3), year, leap.
    st_nxt[8] = st_r[7];
    if (st_r[7].d3 >= 11'(3 * ts2cal_pkg::DAYS_1Y)) begin
      n1 = 2'd3;
    end else if (st_r[7].d3 >= 11'(2 * ts2cal_pkg::DAYS_1Y)) begin
      n1 = 2'd2;
    end else if (st_r[7].d3 >= ts2cal_pkg::DAYS_1Y) begin
      n1 = 2'd1;
    end else begin
      n1 = 2'd0;
    end
    yw = st_r[7].d3 - 11'(11'(n1) * ts2cal_pkg::DAYS_1Y);
    st_nxt[8].yday = yw[8:0];
    st_nxt[8].year = 14'(st_r[7].n400) * 14'd400 + 14'(st_r[7].n100) * 14'd100
                   + 14'(st_r[7].n4) * 14'd4 + 14'(n1) + 14'd1;
    // year divisible by 4 <=> n1 == 3; by 100 also needs n4 == 24; by 400 also n100 == 3
    st_nxt[8].leap = (n1 == 2'd3) && !((st_r[7].n4 == 5'd24) && (st_r[7].n100 != 2'd3));

    // Stage 9: February 29 and the shift of later leap-year days.
    st_nxt[9] = st_r[8];
    st_nxt[9].feb29 = st_r[8].leap && (st_r[8].yday == ts2cal_pkg::LEAP_DAY_YDAY);
    if (st_r[8].leap && (st_r[8].yday > ts2cal_pkg::LEAP_DAY_YDAY)) begin
      st_nxt[9].dd = st_r[8].yday - 9'd1;
    end else begin
      st_nxt[9].dd = st_r[8].yday;
    end

    // Stage 10: month lookup, output forming.
    st_nxt[10] = st_r[9];
    mon0 = '0;
    for (int i = 1; i < 12; i++) begin
      if (st_r[9].dd >= ts2cal_pkg::month_start(4'(i))) begin
        mon0 = mon0 + 4'd1;
      end
    end
    mbeg = ts2cal_pkg::month_start(mon0);
    domw = st_r[9].dd - mbeg + 9'd1;
    if (st_r[9].feb29) begin
      st_nxt[10].mon = 4'd2;
      st_nxt[10].dom = 5'd29;
    end else begin
      st_nxt[10].mon = mon0 + 4'd1;
      st_nxt[10].dom = domw[4:0];
    end
    st_nxt[10].doy = st_r[9].yday + 9'd1;
    if (st_r[9].oor) begin
      st_nxt[10].year = '0;
      st_nxt[10].mon  = '0;
      st_nxt[10].dom  = '0;
      st_nxt[10].doy  = '0;
      st_nxt[10].wd   = '0;
      st_nxt[10].hr   = '0;
      st_nxt[10].mi   = '0;
      st_nxt[10].se   = '0;
    end
  end

  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {4'd0,
                       st_r[NS-1].se, st_r[NS-1].mi, st_r[NS-1].hr, st_r[NS-1].wd,
                       st_r[NS-1].doy, st_r[NS-1].dom, st_r[NS-1].mon, st_r[NS-1].year};
  assign out_tuser  = st_r[NS-1].oor;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("out-of-range item carries nonzero fields");

  a_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      (out_tdata[17:14] != 4'd0) && (out_tdata[17:14] <= 4'd12) && (out_tdata[22:18] != 5'd0))
    else $error("in-range item has bad month or day");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> vld_r[0] && !rdy[1])
    else $error("input stalled while first stage can move");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] && !out_tready |=> vld_r[NS-1] && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled pipeline lost or moved an item");

endmodule
